### rtl/core/wse_pkg.sv
// ----------------------------------------------------------------------------
// wse_pkg: shared types and constants for the windowed slope estimator
// Holds field widths, the history depth and the request and response structs.
// ----------------------------------------------------------------------------
package wse_pkg;

   localparam int MaxWindow = 4;
   localparam int HistDepth = MaxWindow + 1;
   localparam int PtrW = $clog2(HistDepth);
   localparam int TermW = 3;
   localparam int DataW = 32;
   // Dividend |dv*1000| < 2^43, sum of up to 4 slopes < 2^45.
   localparam int NumW = 48;
   localparam int DenW = 33;
   localparam int CntW = $clog2(NumW + 1);
   localparam logic [2:0] WindowReset = 3'd1;
   localparam logic [0:0] RegWindow = 1'b0;

   typedef struct packed {
      logic [DataW-1:0] time_ms;
      logic signed [DataW-1:0] altitude_mm;
      logic signed [DataW-1:0] speed_mm_s;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0] velocity_est_mm_s;
      logic [TermW-1:0] velocity_terms;
      logic signed [DataW-1:0] accel_est_mm_s2;
      logic [TermW-1:0] accel_terms;
      logic clipped;
   } rsp_type;

endpackage

### rtl/core/wse_stream_if.sv
// ----------------------------------------------------------------------------
// wse_stream_if: valid/ready channel
// Carries one payload with a source and a sink modport.
// ----------------------------------------------------------------------------
interface wse_stream_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/core/wse_divider.sv
// ----------------------------------------------------------------------------
// wse_divider: bit-serial signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module wse_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [wse_pkg::NumW-1:0] numer,
   input  logic signed [wse_pkg::DenW-1:0] denom,
   output logic done,
   output logic signed [wse_pkg::NumW-1:0] quot
);
   import wse_pkg::*;

   logic [NumW-1:0] q_ff, q_in;
   logic [DenW:0] rem_ff, rem_in;
   logic [DenW-1:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DenW:0] trial;

   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DenW-1:0], q_ff[NumW-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = numer[NumW-1] ? NumW'(-numer) : NumW'(numer);
         d_in = denom[DenW-1] ? DenW'(-denom) : DenW'(denom);
         neg_in = numer[NumW-1] ^ denom[DenW-1];
         rem_in = '0;
         cnt_in = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DenW]) begin
            rem_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DenW-1:0], q_ff[NumW-1]};
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule

### rtl/core/windowed_slope_estimator.sv
// Windowed slope estimator top level.
// Up to ten serial divisions (four slopes and one mean per estimate) serve one transaction.
// One transaction at a time: the next is taken once the sequencer is back in idle after the
// result is loaded, and that load waits out any output stall.
// Reset (synchronous, active high) empties the history and sets window to 1.
// ----------------------------------------------------------------------------
// windowed_slope_estimator: velocity and acceleration from sample history
// A sequencer walks the intervals, sharing one serial divider for all slopes.
// ----------------------------------------------------------------------------
module windowed_slope_estimator (
   input  logic clock,
   input  logic reset,
   wse_stream_if.sink req,
   wse_stream_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import wse_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PAIR = 3'd1;   // read an interval, launch a slope
   localparam logic [2:0] S_SLOPE = 3'd2;  // wait for one slope quotient
   localparam logic [2:0] S_MEAN = 3'd3;   // launch the mean division
   localparam logic [2:0] S_MWAIT = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   // History store; entries are only read after they are written.
   logic [DataW-1:0] hist_time [HistDepth];
   logic [DataW-1:0] hist_alt [HistDepth];
   logic [DataW-1:0] hist_spd [HistDepth];

   logic [2:0] state_ff, state_in;
   logic [2:0] window_ff;
   logic [PtrW-1:0] wptr_ff, newest_ff;
   logic [2:0] fill_ff;
   logic [2:0] k_ff, k_in, nint_ff;
   logic pass_ff, pass_in;   // 0: altitude, 1: speed
   logic first_ff;
   logic signed [NumW-1:0] sum_ff, sum_in;
   logic [TermW-1:0] n_ff, n_in;
   logic signed [DataW-1:0] vel_ff, vel_in;
   logic [TermW-1:0] vterms_ff, vterms_in;
   logic clip_ff;   // velocity mean saturated for the current transaction
   rsp_type out_ff;
   logic out_valid_ff;

   logic dstart;
   logic signed [NumW-1:0] dnum;
   logic signed [DenW-1:0] dden;
   logic ddone;
   logic signed [NumW-1:0] dquot;

   wse_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .numer(dnum), .denom(dden),
      .done(ddone), .quot(dquot)
   );

   // Configuration: only window exists.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1] == RegWindow) ? {29'd0, window_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WindowReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1] == RegWindow) begin
         window_ff <= csr_pwdata[2:0];
      end
   end

   // Slot k intervals back from the newest sample.
   function automatic logic [PtrW-1:0] back(input logic [PtrW-1:0] base, input logic [2:0] k);
      logic [PtrW:0] t;
      t = {1'b0, base} + (PtrW+1)'(HistDepth) - (PtrW+1)'(k);
      if (t >= (PtrW+1)'(HistDepth)) t = t - (PtrW+1)'(HistDepth);
      return t[PtrW-1:0];
   endfunction

   logic [PtrW-1:0] slot_a, slot_b;
   logic signed [DataW:0] dt, dv;
   logic signed [NumW-1:0] dv1000;
   logic signed [NumW-1:0] mean_res;
   logic mean_clip;
   logic signed [DataW-1:0] mean_sat;
   logic accept;
   logic out_free;

   assign slot_a = back(newest_ff, k_ff);
   assign slot_b = back(newest_ff, k_ff + 3'd1);
   assign dt = $signed({1'b0, hist_time[slot_a]}) - $signed({1'b0, hist_time[slot_b]});
   assign dv = pass_ff
      ? $signed({hist_spd[slot_a][DataW-1], hist_spd[slot_a]})
        - $signed({hist_spd[slot_b][DataW-1], hist_spd[slot_b]})
      : $signed({hist_alt[slot_a][DataW-1], hist_alt[slot_a]})
        - $signed({hist_alt[slot_b][DataW-1], hist_alt[slot_b]});
   // Times 1000 as shifts: 1024 - 16 - 8.
   assign dv1000 = (NumW'(dv) <<< 10) - (NumW'(dv) <<< 4) - (NumW'(dv) <<< 3);

   assign mean_res = dquot;
   assign mean_clip = (mean_res > NumW'(32'sh7fffffff)) || (mean_res < -NumW'(64'sh80000000));
   assign mean_sat = (mean_res > NumW'(32'sh7fffffff)) ? 32'sh7fffffff
                   : (mean_res < -NumW'(64'sh80000000)) ? 32'sh80000000
                   : DataW'(mean_res);

   // The output register parts the two sides: a new transaction may start while
   // the previous result waits, and only the final load waits for it to leave.
   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign out_free = !out_valid_ff || rsp.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      pass_in = pass_ff;
      sum_in = sum_ff;
      n_in = n_ff;
      vel_in = vel_ff;
      vterms_in = vterms_ff;
      dstart = 1'b0;
      dnum = sum_ff;
      dden = DenW'(n_ff);
      case (state_ff)
         S_IDLE: begin
            k_in = '0;
            pass_in = 1'b0;
            sum_in = '0;
            n_in = '0;
            if (accept) state_in = S_PAIR;
         end
         S_PAIR: begin
            if (first_ff) begin
               // First sample: altitude*1000 over its own time stamp.
               if (hist_time[newest_ff] != '0) begin
                  dnum = (NumW'($signed(hist_alt[newest_ff])) <<< 10)
                       - (NumW'($signed(hist_alt[newest_ff])) <<< 4)
                       - (NumW'($signed(hist_alt[newest_ff])) <<< 3);
                  dden = $signed({1'b0, hist_time[newest_ff]});
                  dstart = 1'b1;
                  n_in = TermW'(1);
                  state_in = S_MWAIT;
               end else begin
                  state_in = S_MEAN;
               end
            end else if (k_ff == nint_ff) begin
               state_in = S_MEAN;
            end else if (dt == '0) begin
               k_in = k_ff + 3'd1;
            end else begin
               dnum = dv1000;
               dden = dt;
               dstart = 1'b1;
               state_in = S_SLOPE;
            end
         end
         S_SLOPE: begin
            if (ddone) begin
               sum_in = sum_ff + dquot;
               n_in = n_ff + 1'b1;
               k_in = k_ff + 3'd1;
               state_in = S_PAIR;
            end
         end
         S_MEAN: begin
            if (n_ff == '0) begin
               // No terms: report zero through the same path.
               if (!pass_ff && !first_ff) begin
                  vel_in = '0;
                  vterms_in = '0;
                  pass_in = 1'b1;
                  k_in = '0;
                  sum_in = '0;
                  state_in = S_PAIR;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               dnum = sum_ff;
               dden = DenW'(n_ff);
               dstart = 1'b1;
               state_in = S_MWAIT;
            end
         end
         S_MWAIT: begin
            if (ddone) state_in = S_DONE;
         end
         S_DONE: begin
            if (!pass_ff && !first_ff) begin
               vel_in = mean_sat;
               vterms_in = n_ff;
               pass_in = 1'b1;
               k_in = '0;
               sum_in = '0;
               n_in = '0;
               state_in = S_PAIR;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result assembly happens on leaving S_DONE toward idle.
   logic finish;
   logic clip_v;
   assign finish = (state_ff == S_DONE) && (pass_ff || first_ff) && out_free;
   assign clip_v = first_ff ? 1'b0 : clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wptr_ff <= '0;
         fill_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            wptr_ff <= (wptr_ff == PtrW'(HistDepth - 1)) ? '0 : wptr_ff + 1'b1;
            if (fill_ff < 3'(HistDepth)) fill_ff <= fill_ff + 3'd1;
         end
         if (finish) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
      k_ff <= k_in;
      pass_ff <= pass_in;
      sum_ff <= sum_in;
      n_ff <= n_in;
      vel_ff <= vel_in;
      vterms_ff <= vterms_in;
      if (accept) begin
         hist_time[wptr_ff] <= req.data.time_ms;
         hist_alt[wptr_ff] <= req.data.altitude_mm;
         hist_spd[wptr_ff] <= req.data.speed_mm_s;
         newest_ff <= wptr_ff;
         first_ff <= (fill_ff == '0);
         // Intervals used: min(fill, clamped window).
         nint_ff <= (fill_ff < ((window_ff == '0) ? 3'd1 :
                    (window_ff > 3'(MaxWindow)) ? 3'(MaxWindow) : window_ff))
                    ? fill_ff
                    : ((window_ff == '0) ? 3'd1 :
                       (window_ff > 3'(MaxWindow)) ? 3'(MaxWindow) : window_ff);
         clip_ff <= 1'b0;
      end
      // Track saturation of the velocity mean as it is taken.
      if (state_ff == S_DONE && !pass_ff && !first_ff && n_ff != '0 && mean_clip)
         clip_ff <= 1'b1;
      if (finish) begin
         if (first_ff) begin
            out_ff.velocity_est_mm_s <= (n_ff == '0) ? '0 : mean_sat;
            out_ff.velocity_terms <= n_ff;
            out_ff.accel_est_mm_s2 <= '0;
            out_ff.accel_terms <= '0;
            out_ff.clipped <= (n_ff != '0) && mean_clip;
         end else begin
            out_ff.velocity_est_mm_s <= vel_ff;
            out_ff.velocity_terms <= vterms_ff;
            out_ff.accel_est_mm_s2 <= (n_ff == '0) ? '0 : mean_sat;
            out_ff.accel_terms <= n_ff;
            out_ff.clipped <= clip_v || ((n_ff != '0) && mean_clip);
         end
      end
   end
endmodule
